[rtl/ifsd_pkg.sv]
// shared types and constants for the image file signature detector
package ifsd_pkg;

	// file kind codes
	localparam logic [3:0] KIND_UNKNOWN = 4'd0;
	localparam logic [3:0] KIND_GIF     = 4'd1;
	localparam logic [3:0] KIND_JPEG    = 4'd2;
	localparam logic [3:0] KIND_PNG     = 4'd3;
	localparam logic [3:0] KIND_SWF     = 4'd4;
	localparam logic [3:0] KIND_PSD     = 4'd5;
	localparam logic [3:0] KIND_BMP     = 4'd6;
	localparam logic [3:0] KIND_TIFF_LE = 4'd7;
	localparam logic [3:0] KIND_TIFF_BE = 4'd8;
	localparam logic [3:0] KIND_JPC     = 4'd9;
	localparam logic [3:0] KIND_JP2     = 4'd10;
	localparam logic [3:0] KIND_IFF     = 4'd11;
	localparam logic [3:0] KIND_WBMP    = 4'd12;
	localparam logic [3:0] KIND_SWC     = 4'd13;

	// fault codes
	localparam logic [1:0] FAULT_NONE  = 2'd0;
	localparam logic [1:0] FAULT_SHORT = 2'd1;
	localparam logic [1:0] FAULT_PNG   = 2'd2;

	// header bytes kept per file
	localparam int unsigned HEAD_BYTES = 12;
	localparam logic [3:0]  HEAD_FULL  = 4'd12;

	// signatures, first byte in the top bits
	localparam logic [23:0] SIG_GIF    = 24'h474946;
	localparam logic [23:0] SIG_JPEG   = 24'hffd8ff;
	localparam logic [23:0] SIG_PNG_PFX = 24'h89504e;
	localparam logic [63:0] SIG_PNG    = 64'h89504e470d0a1a0a;
	localparam logic [23:0] SIG_SWF    = 24'h465753;
	localparam logic [23:0] SIG_SWC    = 24'h435753;
	localparam logic [23:0] SIG_PSD    = 24'h384250;
	localparam logic [15:0] SIG_BMP    = 16'h424d;
	localparam logic [23:0] SIG_JPC    = 24'hff4fff;
	localparam logic [31:0] SIG_TIFF_LE = 32'h49492a00;
	localparam logic [31:0] SIG_TIFF_BE = 32'h4d4d002a;
	localparam logic [31:0] SIG_IFF    = 32'h464f524d;
	localparam logic [95:0] SIG_JP2    = 96'h0000000c6a5020200d0a870a;

	// varint bits
	localparam logic [7:0] VARINT_MORE = 8'h80;

	// wbmp header parse phases
	typedef enum logic [5:0] {
		PH_TYPE = 6'b000001,
		PH_SKIP = 6'b000010,
		PH_COLS = 6'b000100,
		PH_ROWS = 6'b001000,
		PH_DONE = 6'b010000,
		PH_FAIL = 6'b100000
	} wbmp_phase_t;

	// wbmp parser status after the current byte
	typedef struct packed {
		logic done;
		logic fail;
	} wbmp_stat_t;

endpackage

[rtl/ifsd_wbmp.sv]
// wbmp header parser with 7-bit continuation varints for width and height
module ifsd_wbmp #(
	parameter int DIM_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                feed,
	input  logic                clear,
	input  logic [7:0]          data_byte,
	output ifsd_pkg::wbmp_stat_t stat,
	output logic [DIM_BITS-1:0] col_next,
	output logic [DIM_BITS-1:0] row_next
);
	import ifsd_pkg::*;

	wbmp_phase_t         phase_q;
	wbmp_phase_t         phase_next;
	logic [DIM_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] row_q;
	logic                more;

	assign more = (data_byte & VARINT_MORE) != 8'h00;

	// next phase and accumulators for the current byte
	always_comb begin
		phase_next = phase_q;
		col_next   = col_q;
		row_next   = row_q;
		if (feed) begin
			unique case (phase_q)
				PH_TYPE: begin
					phase_next = (data_byte == 8'h00) ? PH_SKIP : PH_FAIL;
				end
				PH_SKIP: begin
					if (!more) phase_next = PH_COLS;
				end
				PH_COLS: begin
					col_next = {col_q[DIM_BITS-8:0], data_byte[6:0]};
					if (!more) phase_next = PH_ROWS;
				end
				PH_ROWS: begin
					row_next = {row_q[DIM_BITS-8:0], data_byte[6:0]};
					if (!more) phase_next = PH_DONE;
				end
				PH_DONE, PH_FAIL: begin
					phase_next = phase_q;
				end
				default: begin
					phase_next = phase_q;
				end
			endcase
		end
	end

	assign stat.done = (phase_next == PH_DONE);
	assign stat.fail = (phase_next == PH_FAIL);

	// parser state, cleared at end of file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			col_q   <= '0;
			row_q   <= '0;
		end else if (clear) begin
			phase_q <= PH_TYPE;
			col_q   <= '0;
			row_q   <= '0;
		end else if (feed) begin
			phase_q <= phase_next;
			col_q   <= col_next;
			row_q   <= row_next;
		end
	end

endmodule

[rtl/image_file_signature_detector_core.sv]
// top level of the image file signature detector
//
// Input channel: one file byte per transaction (data_byte, end_of_file) on
// byte_valid / byte_stall; end_of_file marks the last byte of a file and the
// next transaction starts a new file.
// Output channel: at most one verdict per file (file_kind, fault_code,
// wbmp_columns, wbmp_rows) on result_valid / result_stall. The verdict comes
// on the byte that decides it, or on the end-of-file byte if nothing
// decided earlier; bytes after a verdict only wait for the end mark.
// Throughput: one byte per cycle while byte_stall is low; each byte passes
// once through the input register, the signature compare and varint update,
// and the result register. When result_stall holds the output register
// full, the input register still takes one byte and byte_stall then rises
// until the verdict is taken.
// Reset (arst_n low) empties both registers and starts a new file: byte
// count zero, wbmp parser back to the type byte, no verdict given.
module image_file_signature_detector_core #(
	parameter int DIM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  file_kind,
	output logic [1:0]  fault_code,
	output logic [31:0] wbmp_columns,
	output logic [31:0] wbmp_rows
);
	import ifsd_pkg::*;

	localparam int WIDE_BITS = (DIM_BITS > 32) ? DIM_BITS : 32;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;

	// per-file state
	logic [3:0] cnt_q;
	logic       verdict_q;
	logic [7:0] head_q [HEAD_BYTES];

	// result register
	logic        out_valid_q;
	logic [3:0]  kind_q;
	logic [1:0]  fault_q;
	logic [31:0] cols_q;
	logic [31:0] rows_q;

	logic                out_free;
	logic                fire;
	logic                store;
	logic                feed;
	logic [3:0]          cnt_next;
	logic [7:0]          head_next [HEAD_BYTES];
	logic [95:0]         head_cat;
	logic                png;
	logic                decided;
	logic [3:0]          kind_d;
	logic [1:0]          fault_d;
	logic                emit;
	logic [3:0]          kind_r;
	logic [1:0]          fault_r;
	logic [31:0]         cols_r;
	logic [31:0]         rows_r;
	wbmp_stat_t          wstat;
	logic [DIM_BITS-1:0] col_next;
	logic [DIM_BITS-1:0] row_next;
	logic [WIDE_BITS-1:0] col_wide;
	logic [WIDE_BITS-1:0] row_wide;

	// flow control
	assign out_free   = !out_valid_q || !result_stall;
	assign byte_stall = valid_s1 && !out_free;
	assign fire       = valid_s1 && out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	// header capture
	assign feed     = fire && !verdict_q;
	assign store    = feed && (cnt_q < HEAD_FULL);
	assign cnt_next = store ? cnt_q + 4'd1 : cnt_q;

	always_comb begin
		for (int i = 0; i < HEAD_BYTES; i++) begin
			head_next[i] = (store && cnt_q == 4'(i)) ? byte_s1 : head_q[i];
			head_cat[95-8*i -: 8] = head_next[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < HEAD_BYTES; i++) begin
			if (store && cnt_q == 4'(i)) head_q[i] <= byte_s1;
		end
	end

	// wbmp header parser
	ifsd_wbmp #(
		.DIM_BITS(DIM_BITS)
	) u_wbmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.clear    (fire && eof_s1),
		.data_byte(byte_s1),
		.stat     (wstat),
		.col_next (col_next),
		.row_next (row_next)
	);

	assign col_wide = WIDE_BITS'(col_next);
	assign row_wide = WIDE_BITS'(row_next);

	// signature decision in priority order
	assign png = (cnt_next >= 4'd3) && (head_cat[95:72] == SIG_PNG_PFX);

	always_comb begin
		decided = 1'b0;
		kind_d  = KIND_UNKNOWN;
		fault_d = FAULT_NONE;
		if (cnt_next == 4'd3) begin
			decided = 1'b1;
			priority if (head_cat[95:72] == SIG_GIF) kind_d = KIND_GIF;
			else if (head_cat[95:72] == SIG_JPEG)    kind_d = KIND_JPEG;
			else if (png)                            decided = 1'b0;
			else if (head_cat[95:72] == SIG_SWF)     kind_d = KIND_SWF;
			else if (head_cat[95:72] == SIG_SWC)     kind_d = KIND_SWC;
			else if (head_cat[95:72] == SIG_PSD)     kind_d = KIND_PSD;
			else if (head_cat[95:80] == SIG_BMP)     kind_d = KIND_BMP;
			else if (head_cat[95:72] == SIG_JPC)     kind_d = KIND_JPC;
			else                                     decided = 1'b0;
		end else if (png) begin
			if (cnt_next == 4'd8) begin
				decided = 1'b1;
				if (head_cat[95:32] == SIG_PNG) begin
					kind_d = KIND_PNG;
				end else begin
					fault_d = FAULT_PNG;
				end
			end
		end else if (cnt_next == 4'd4) begin
			decided = 1'b1;
			priority if (head_cat[95:64] == SIG_TIFF_LE) kind_d = KIND_TIFF_LE;
			else if (head_cat[95:64] == SIG_TIFF_BE)     kind_d = KIND_TIFF_BE;
			else if (head_cat[95:64] == SIG_IFF)         kind_d = KIND_IFF;
			else                                         decided = 1'b0;
		end else if (cnt_next >= HEAD_FULL) begin
			decided = 1'b1;
			priority if (store && head_cat == SIG_JP2) kind_d = KIND_JP2;
			else if (wstat.done)                       kind_d = KIND_WBMP;
			else if (wstat.fail)                       kind_d = KIND_UNKNOWN;
			else                                       decided = 1'b0;
		end
	end

	// result for this byte: a decided verdict or the end-of-file fallback
	always_comb begin
		emit    = 1'b0;
		kind_r  = kind_d;
		fault_r = fault_d;
		if (!verdict_q) begin
			if (decided) begin
				emit = 1'b1;
			end else if (eof_s1) begin
				emit    = 1'b1;
				kind_r  = KIND_UNKNOWN;
				fault_r = (cnt_next < HEAD_FULL) ? FAULT_SHORT : FAULT_NONE;
			end
		end
		cols_r = (kind_r == KIND_WBMP) ? col_wide[31:0] : 32'd0;
		rows_r = (kind_r == KIND_WBMP) ? row_wide[31:0] : 32'd0;
	end

	// per-file control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			verdict_q <= 1'b0;
		end else if (fire) begin
			if (eof_s1) begin
				cnt_q     <= '0;
				verdict_q <= 1'b0;
			end else begin
				cnt_q     <= cnt_next;
				verdict_q <= verdict_q || decided;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q  <= kind_r;
			fault_q <= fault_r;
			cols_q  <= cols_r;
			rows_q  <= rows_r;
		end
	end

	assign result_valid = out_valid_q;
	assign file_kind    = kind_q;
	assign fault_code   = fault_q;
	assign wbmp_columns = cols_q;
	assign wbmp_rows    = rows_q;

	// dimensions only accompany a wbmp verdict
	a_dims_wbmp_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && file_kind != KIND_WBMP |-> wbmp_columns == 32'd0 && wbmp_rows == 32'd0)
		else $error("wbmp dimensions on a non-wbmp verdict");

	// a fault always comes with an unknown kind
	a_fault_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && fault_code != FAULT_NONE |-> file_kind == KIND_UNKNOWN)
		else $error("fault reported with a known kind");

	// an end-of-file byte starts a fresh file
	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && eof_s1 |=> !verdict_q && cnt_q == 4'd0)
		else $error("file state not cleared after end of file");

	// byte count saturates at the header size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HEAD_FULL)
		else $error("header byte count out of range");

endmodule
